@@ rtl/bhmp_pkg.sv @@
// Package for the binary HTTP message parser: phase codes, result kinds, error codes.
// Used by bhmp_core and binary_http_message_parser.
package bhmp_pkg;

  localparam int LengthBits = 32;

  localparam logic [4:0] PH_FRAMING     = 5'd0;
  localparam logic [4:0] PH_METHOD_LEN  = 5'd1;
  localparam logic [4:0] PH_SCHEME_LEN  = 5'd3;
  localparam logic [4:0] PH_AUTH_LEN    = 5'd5;
  localparam logic [4:0] PH_PATH_LEN    = 5'd7;
  localparam logic [4:0] PH_HNAME_LEN   = 5'd9;
  localparam logic [4:0] PH_HVAL_LEN    = 5'd11;
  localparam logic [4:0] PH_CONTENT_LEN = 5'd13;
  localparam logic [4:0] PH_TNAME_LEN   = 5'd15;
  localparam logic [4:0] PH_TVAL_LEN    = 5'd17;
  localparam logic [4:0] PH_STATUS      = 5'd19;
  localparam logic [4:0] PH_HSEC        = 5'd20;
  localparam logic [4:0] PH_TSEC        = 5'd21;
  localparam logic [4:0] PH_DONE        = 5'd22;

  localparam logic [3:0] KIND_FRAMING  = 4'd0;
  localparam logic [3:0] KIND_METHOD   = 4'd1;
  localparam logic [3:0] KIND_SCHEME   = 4'd2;
  localparam logic [3:0] KIND_AUTH     = 4'd3;
  localparam logic [3:0] KIND_PATH     = 4'd4;
  localparam logic [3:0] KIND_STATUS   = 4'd5;
  localparam logic [3:0] KIND_HNAME    = 4'd6;
  localparam logic [3:0] KIND_HVAL     = 4'd7;
  localparam logic [3:0] KIND_CONTENT  = 4'd8;
  localparam logic [3:0] KIND_TNAME    = 4'd9;
  localparam logic [3:0] KIND_TVAL     = 4'd10;
  localparam logic [3:0] KIND_ERROR    = 4'd11;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_TRUNC     = 4'd1;
  localparam logic [3:0] ERR_FRAMING   = 4'd2;
  localparam logic [3:0] ERR_INDET     = 4'd3;
  localparam logic [3:0] ERR_OVERRUN   = 4'd4;
  localparam logic [3:0] ERR_SCHEME    = 4'd5;
  localparam logic [3:0] ERR_STATUS    = 4'd6;
  localparam logic [3:0] ERR_SECTION   = 4'd7;
  localparam logic [3:0] ERR_NOHEADERS = 4'd8;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] payload_byte;
    logic       field_last;
    logic       field_empty;
    logic [9:0] number_value;
    logic       is_request;
    logic       secure;
    logic [3:0] error_code;
    logic       message_done;
  } result_t;

  // kind of the field whose length phase is given (odd phases 1..17)
  function automatic logic [3:0] field_kind(input logic [4:0] lenph);
    case (lenph)
      PH_METHOD_LEN:  field_kind = KIND_METHOD;
      PH_SCHEME_LEN:  field_kind = KIND_SCHEME;
      PH_AUTH_LEN:    field_kind = KIND_AUTH;
      PH_PATH_LEN:    field_kind = KIND_PATH;
      PH_HNAME_LEN:   field_kind = KIND_HNAME;
      PH_HVAL_LEN:    field_kind = KIND_HVAL;
      PH_CONTENT_LEN: field_kind = KIND_CONTENT;
      PH_TNAME_LEN:   field_kind = KIND_TNAME;
      PH_TVAL_LEN:    field_kind = KIND_TVAL;
      default:        field_kind = KIND_FRAMING;
    endcase
  endfunction

  function automatic logic [7:0] https_char(input logic [2:0] idx);
    case (idx)
      3'd0:    https_char = 8'h68;
      3'd1:    https_char = 8'h74;
      3'd2:    https_char = 8'h74;
      3'd3:    https_char = 8'h70;
      3'd4:    https_char = 8'h73;
      default: https_char = 8'h00;
    endcase
  endfunction

endpackage

@@ rtl/binary_http_message_parser.sv @@
// Top level of the binary HTTP message parser: input register, core, output skid.
// Depends on bhmp_pkg and bhmp_core.
//
// Takes one byte of a known-length binary HTTP message per transfer and gives at
// most one tagged result per byte, presented from the output register once the byte
// has passed the input register and the core update. A byte is accepted every cycle
// while the output side drains; the rate is one byte per clock, set by the update of
// the phase and counter registers on each accepted byte. A stalled output parks one
// result in the skid entry, after which s_tready drops until that entry drains.
// Errors hold until a byte marked as a message start.
module binary_http_message_parser
  import bhmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // data_byte[7:0], bytes_left[39:8]
  input  logic        s_tuser,  // message_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // payload_byte[7:0], field_last[8], field_empty[9],
                                // number_value[19:10], is_request[20], secure[21],
                                // message_done[22], zero[23]
  output logic [7:0]  m_tuser   // kind[3:0], error_code[7:4]
);

  logic        iv;
  logic [39:0] idata;
  logic        istart;
  logic        rv;
  result_t     r;
  result_t     ob;
  logic        ov;
  result_t     sb;
  logic        sv;

  // ready as long as the skid slot is free
  assign s_tready = ~sv;

  always_ff @(posedge clk) begin
    if (rst) iv <= 1'b0;
    else if (s_tready) iv <= s_tvalid;
    if (s_tready) begin
      idata  <= s_tdata;
      istart <= s_tuser;
    end
  end

  bhmp_core u_core (
    .clk(clk), .rst(rst), .in_valid(iv & s_tready),
    .data_byte(idata[7:0]), .bytes_left(idata[39:8]), .message_start(istart),
    .res_valid(rv), .res(r)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      if (!ov || m_tready) begin
        if (sv) begin
          ov <= 1'b1; ob <= sb; sv <= 1'b0;
        end else begin
          ov <= rv & iv; ob <= r;
        end
      end else if (rv && iv && !sv) begin
        sv <= 1'b1; sb <= r;
      end
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {1'b0, ob.message_done, ob.secure, ob.is_request, ob.number_value,
                     ob.field_empty, ob.field_last, ob.payload_byte};
  assign m_tuser  = {ob.error_code, ob.kind};

endmodule

@@ rtl/bhmp_core.sv @@
// Parser state and per-byte decode for the binary HTTP message parser.
// Depends on bhmp_pkg; one registered byte in, at most one result out per cycle.
module bhmp_core
  import bhmp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    data_byte,
  input  logic [31:0]   bytes_left,
  input  logic          message_start,
  output logic          res_valid,
  output result_t       res
);

  logic [4:0]  phase, phase_next;
  logic [61:0] acc, acc_next;
  logic [2:0]  pend, pend_next;
  logic [31:0] fleft, fleft_next;
  logic [31:0] sleft, sleft_next;
  logic        req, req_next;
  logic [2:0]  smatch, smatch_next;
  logic        pair_seen, pair_seen_next;
  logic        err_hold, err_hold_next;

  // state after an optional restart
  logic [4:0]  ph0;
  logic [61:0] acc0;
  logic [2:0]  pend0;
  logic [31:0] fleft0, sleft0;
  logic        req0, pair0, err0;
  logic [2:0]  sm0;

  logic [61:0] v;
  logic [31:0] avail;
  logic [3:0]  size;
  logic        v_big;
  logic [4:0]  lenph;
  logic        last;
  logic [2:0]  sm_upd;
  logic        sec_zero;
  logic        fe_done;
  logic [4:0]  fe_phase;
  logic        fe_smclr;
  logic        fe_pair;

  always_comb begin
    ph0 = phase; acc0 = acc; pend0 = pend; fleft0 = fleft; sleft0 = sleft;
    req0 = req; pair0 = pair_seen; err0 = err_hold; sm0 = smatch;
    if (message_start) begin
      ph0 = PH_FRAMING; acc0 = '0; pend0 = '0; fleft0 = '0; sleft0 = '0;
      req0 = 1'b0; pair0 = 1'b0; err0 = 1'b0; sm0 = '0;
    end
  end

  always_comb begin
    phase_next = ph0; acc_next = acc0; pend_next = pend0; fleft_next = fleft0;
    sleft_next = sleft0; req_next = req0; smatch_next = sm0;
    pair_seen_next = pair0; err_hold_next = err0;
    res = '0;
    res_valid = 1'b0;
    v = '0; size = '0; lenph = '0; last = 1'b0; sm_upd = sm0;
    sec_zero = 1'b0; fe_done = 1'b0; fe_phase = '0; fe_smclr = 1'b0; fe_pair = 1'b0;
    avail = (bytes_left != 32'd0) ? bytes_left - 32'd1 : 32'd0;
    v_big = 1'b0;

    if (in_valid && !err0 && ph0 < PH_DONE) begin
      // section byte budget shrinks on every byte inside a section
      if (((ph0 >= PH_HNAME_LEN) && (ph0 <= PH_HVAL_LEN + 5'd1)) ||
          ((ph0 >= PH_TNAME_LEN) && (ph0 <= PH_TVAL_LEN + 5'd1))) begin
        if (sleft0 != 32'd0) sleft_next = sleft0 - 32'd1;
      end
      sec_zero = (sleft_next == 32'd0);

      if (ph0 >= 5'd1 && ph0 <= 5'd18 && !ph0[0]) begin
        lenph = ph0 - 5'd1;
        last = (fleft0 <= 32'd1);
      end else if (ph0 >= 5'd1 && ph0 <= 5'd18) begin
        lenph = ph0;
        last = 1'b1;
      end

      // where a finished field leads
      case (lenph)
        PH_METHOD_LEN:  begin fe_phase = PH_SCHEME_LEN; fe_smclr = 1'b1; end
        PH_PATH_LEN:    fe_phase = PH_HSEC;
        PH_HNAME_LEN:   fe_phase = PH_HVAL_LEN;
        PH_HVAL_LEN:    begin
          fe_pair = 1'b1;
          fe_phase = sec_zero ? PH_CONTENT_LEN : PH_HNAME_LEN;
        end
        PH_CONTENT_LEN: fe_phase = PH_TSEC;
        PH_TNAME_LEN:   fe_phase = PH_TVAL_LEN;
        PH_TVAL_LEN:    begin
          fe_done = sec_zero;
          fe_phase = sec_zero ? PH_DONE : PH_TNAME_LEN;
        end
        default:        fe_phase = lenph + 5'd2;
      endcase

      if (ph0 >= 5'd1 && ph0 <= 5'd18 && !ph0[0]) begin
        res_valid = 1'b1;
        res.kind = field_kind(lenph);
        res.payload_byte = data_byte;
        res.field_last = last;
        res.is_request = req0;
        res.message_done = last & fe_done;
        if (fleft0 != 32'd0) fleft_next = fleft0 - 32'd1;
        if (lenph == PH_SCHEME_LEN) begin
          sm_upd = (sm0 < 3'd5 && data_byte == https_char(sm0)) ? sm0 + 3'd1 : 3'd7;
          smatch_next = sm_upd;
          if (last) begin
            if (sm_upd == 3'd5) res.secure = 1'b1;
            else if (sm_upd != 3'd4) begin
              res = '0;
              res.kind = KIND_ERROR;
              res.is_request = req0;
              res.error_code = ERR_SCHEME;
              err_hold_next = 1'b1;
            end
          end
        end
        if (last && !(err_hold_next && !err0)) begin
          phase_next = fe_phase;
          if (fe_smclr) smatch_next = '0;
          if (fe_pair) pair_seen_next = 1'b1;
        end
      end else begin
        if (pend0 == 3'd0) begin
          size = 4'd1 << data_byte[7:6];
          v = {56'd0, data_byte[5:0]};
          pend_next = size[2:0] - 3'd1;
        end else begin
          pend_next = pend0 - 3'd1;
          v = {acc0[53:0], data_byte};
        end
        v_big = (v > {30'd0, avail}) || (v[61:LengthBits] != '0);
        if (pend0 == 3'd0 && {28'd0, size} > bytes_left) begin
          res_valid = 1'b1;
          res.kind = KIND_ERROR;
          res.is_request = req0;
          res.error_code = ERR_TRUNC;
          err_hold_next = 1'b1;
          pend_next = pend0;
        end else begin
          acc_next = v;
          if (pend_next == 3'd0) begin
            case (ph0)
              PH_FRAMING: begin
                req_next = ~v[0];
                res_valid = 1'b1;
                res.is_request = ~v[0];
                if (v > 62'd3 || v[1]) begin
                  res.kind = KIND_ERROR;
                  res.error_code = (v > 62'd3) ? ERR_FRAMING : ERR_INDET;
                  err_hold_next = 1'b1;
                end else begin
                  res.kind = KIND_FRAMING;
                  res.number_value = v[9:0];
                  phase_next = v[0] ? PH_STATUS : PH_METHOD_LEN;
                end
              end
              PH_STATUS: begin
                res_valid = 1'b1;
                res.is_request = req0;
                if (v < 62'd200 || v > 62'd599) begin
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_STATUS;
                  err_hold_next = 1'b1;
                end else begin
                  res.kind = KIND_STATUS;
                  res.number_value = v[9:0];
                  phase_next = PH_HSEC;
                end
              end
              PH_HSEC, PH_TSEC: begin
                if (v_big || (ph0 == PH_HSEC && v == '0)) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.is_request = req0;
                  res.error_code = v_big ? ERR_SECTION : ERR_NOHEADERS;
                  err_hold_next = 1'b1;
                end else if (v == '0) begin
                  res_valid = 1'b1;
                  res.kind = KIND_TNAME;
                  res.is_request = req0;
                  res.field_last = 1'b1;
                  res.field_empty = 1'b1;
                  res.message_done = 1'b1;
                  phase_next = PH_DONE;
                end else begin
                  sleft_next = v[31:0];
                  if (ph0 == PH_HSEC) begin
                    pair_seen_next = 1'b0;
                    phase_next = PH_HNAME_LEN;
                  end else begin
                    phase_next = PH_TNAME_LEN;
                  end
                end
              end
              default: begin
                res_valid = 1'b1;
                res.is_request = req0;
                if (v_big || (v == '0 && ph0 == PH_SCHEME_LEN)) begin
                  res.kind = KIND_ERROR;
                  res.error_code = v_big ? ERR_OVERRUN : ERR_SCHEME;
                  err_hold_next = 1'b1;
                end else if (v == '0) begin
                  res.kind = field_kind(ph0);
                  res.field_last = 1'b1;
                  res.field_empty = 1'b1;
                  res.message_done = fe_done;
                  phase_next = fe_phase;
                  if (fe_smclr) smatch_next = '0;
                  if (fe_pair) pair_seen_next = 1'b1;
                end else begin
                  res_valid = 1'b0;
                  fleft_next = v[31:0];
                  phase_next = ph0 + 5'd1;
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FRAMING; acc <= '0; pend <= '0; fleft <= '0; sleft <= '0;
      req <= 1'b0; smatch <= '0; pair_seen <= 1'b0; err_hold <= 1'b0;
    end else if (in_valid) begin
      phase <= phase_next; acc <= acc_next; pend <= pend_next;
      fleft <= fleft_next; sleft <= sleft_next; req <= req_next;
      smatch <= smatch_next; pair_seen <= pair_seen_next; err_hold <= err_hold_next;
    end
  end

endmodule
